FILE: src/spld_pkg.sv
// Shared types and constants for the shifted run-length line decoder.
// Used by spld_cfg, spld_core, spld_drain and the top level; no dependencies.
package spld_pkg;

	localparam int MAX_LINE_BITS = 16384;

	localparam int OFS_W     = 14;
	localparam int LEN_W     = 15;
	localparam int CNT_OUT_W = 12;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int NRUN      = 4;

	// effective line length in bits, one spare bit for the round-up add
	localparam int EW = (($clog2(MAX_LINE_BITS + 1) > LEN_W) ?
		$clog2(MAX_LINE_BITS + 1) : LEN_W) + 1;
	// byte counts within a line; wide enough for offset/8 as well
	localparam int CNT_W = $clog2((MAX_LINE_BITS + 7) / 8 + 1);
	localparam int BW    = ((CNT_W > 11) ? CNT_W : 11) + 1;

	localparam logic REG_OFFSET = 1'b0;
	localparam logic REG_LINE   = 1'b1;

	typedef struct packed {
		logic [OFS_W-1:0] bit_offset;
		logic [LEN_W-1:0] line_bits;
	} cfg_t;

	typedef struct packed {
		logic [7:0]           value;
		logic [CNT_OUT_W-1:0] count;
		logic                 done;
	} run_t;

	typedef struct packed {
		logic [NRUN-1:0] mask;
		run_t [NRUN-1:0] runs;
	} grp_t;

	function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [BW-1:0] n);
		logic [BW+CNT_OUT_W-1:0] w;
		w = (BW + CNT_OUT_W)'(n);
		return w[CNT_OUT_W-1:0];
	endfunction

endpackage

FILE: src/spld_cfg.sv
// APB register file: bit offset and line length.
// Depends on spld_pkg.
module spld_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spld_pkg::ADDR_W-1:0]  paddr,
	input  logic [spld_pkg::DATA_W-1:0]  pwdata,
	output logic [spld_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output spld_pkg::cfg_t               cfg
);

	logic [spld_pkg::OFS_W-1:0] offset_q;
	logic [spld_pkg::LEN_W-1:0] line_q;
	logic                       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			line_q   <= '0;
		end else if (wr) begin
			case (paddr[2])
				spld_pkg::REG_OFFSET: offset_q <= pwdata[spld_pkg::OFS_W-1:0];
				spld_pkg::REG_LINE:   line_q   <= pwdata[spld_pkg::LEN_W-1:0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			spld_pkg::REG_OFFSET: prdata = spld_pkg::DATA_W'(offset_q);
			spld_pkg::REG_LINE:   prdata = spld_pkg::DATA_W'(line_q);
			default:              prdata = '0;
		endcase
	end

	assign cfg.bit_offset = offset_q;
	assign cfg.line_bits  = line_q;

endmodule

FILE: src/spld_core.sv
// Input register, parse/shift state and single-pass run builder.
// Depends on spld_pkg; feeds one run group per beat to spld_drain.
module spld_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           code_valid,
	output logic           code_stall,
	input  logic [7:0]     code_byte,
	input  logic           end_of_code,
	input  spld_pkg::cfg_t cfg,
	input  logic           grp_ready,
	output logic           grp_load,
	output spld_pkg::grp_t grp
);

	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_LIT = 2'd1;
	localparam logic [1:0] PH_REP = 2'd2;

	localparam int BW = spld_pkg::BW;
	localparam int EW = spld_pkg::EW;

	logic       itm_valid_s1;
	logic [7:0] itm_byte_s1;
	logic       itm_last_s1;

	logic [1:0]    phase_q;
	logic [7:0]    left_q;
	logic [7:0]    carry_q;
	logic [BW-1:0] pos_q;
	logic          started_q;

	logic          accept, adv;
	logic [2:0]    rsh;
	logic [15:0]   sh;
	logic [7:0]    hi, lo;
	logic [EW-1:0] lbx, eff;
	logic [BW-1:0] cap, flr, lead_raw, lead;
	logic [BW-1:0] b0, b1, b2, b3, room, cnt, blx;
	logic [7:0]    c0, carry_n, left_n;
	logic [1:0]    phase_n;
	logic          va, vb, vc, vd, ve;
	logic [7:0]    val_b, val_c;
	logic [BW-1:0] ndata;

	assign adv        = itm_valid_s1 && grp_ready;
	assign code_stall = itm_valid_s1 && !grp_ready;
	assign accept     = code_valid && !code_stall;
	assign grp_load   = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_valid_s1 <= 1'b0;
		end else if (accept) begin
			itm_valid_s1 <= 1'b1;
		end else if (adv) begin
			itm_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			itm_byte_s1 <= code_byte;
			itm_last_s1 <= end_of_code;
		end
	end

	always_comb begin
		rsh = cfg.bit_offset[2:0];
		sh  = {itm_byte_s1, 8'h00} >> rsh;
		hi  = sh[15:8];
		lo  = sh[7:0];

		lbx = EW'(cfg.line_bits);
		eff = (lbx > EW'(spld_pkg::MAX_LINE_BITS)) ? EW'(spld_pkg::MAX_LINE_BITS) : lbx;
		cap = BW'((eff + EW'(7)) >> 3);
		flr = BW'(eff >> 3);

		lead_raw = BW'(cfg.bit_offset[spld_pkg::OFS_W-1:3]);
		lead     = (lead_raw > cap) ? cap : lead_raw;

		b0 = started_q ? pos_q : '0;
		c0 = started_q ? carry_q : 8'h00;
		va = !started_q && (lead != '0);
		b1 = started_q ? b0 : b0 + lead;

		room = (b1 < flr) ? flr - b1 : '0;
		blx  = BW'(left_q);
		cnt  = (blx < room) ? blx : room;

		phase_n = PH_HDR;
		left_n  = left_q;
		carry_n = c0;
		vb      = 1'b0;
		vc      = 1'b0;
		val_b   = c0 | hi;
		val_c   = lo | hi;
		ndata   = '0;

		case (phase_q)
			PH_HDR: begin
				if (!itm_byte_s1[7]) begin
					left_n  = itm_byte_s1 + 8'd1;
					phase_n = PH_LIT;
				end else begin
					left_n  = 8'(9'd257 - {1'b0, itm_byte_s1});
					phase_n = PH_REP;
				end
			end
			PH_LIT: begin
				if (room != '0) begin
					vb      = 1'b1;
					carry_n = lo;
					ndata   = BW'(1);
				end
				left_n  = left_q - 8'd1;
				phase_n = (left_n == 8'd0) ? PH_HDR : PH_LIT;
			end
			PH_REP: begin
				if (cnt != '0) begin
					vb      = 1'b1;
					vc      = (cnt > BW'(1));
					carry_n = lo;
					ndata   = cnt;
				end
				left_n  = 8'd0;
				phase_n = PH_HDR;
			end
			default: begin
				left_n  = 8'd0;
				phase_n = PH_HDR;
			end
		endcase

		b2 = b1 + ndata;
		// line close: leftover carry byte, then zero fill
		vd = itm_last_s1 && (b2 < cap);
		b3 = b2 + BW'(1);
		ve = vd && (b3 < cap);

		grp.mask = {ve, vd, vc, va | vb};

		grp.runs[0].value = va ? 8'h00 : val_b;
		grp.runs[0].count = va ? spld_pkg::cnt_out(lead) : spld_pkg::CNT_OUT_W'(1);
		grp.runs[0].done  = va ? (lead == cap) : ((b1 < cap) && (b1 + BW'(1) >= cap));

		grp.runs[1].value = val_c;
		grp.runs[1].count = spld_pkg::cnt_out(cnt - BW'(1));
		grp.runs[1].done  = (b1 + BW'(1) < cap) && (b2 >= cap);

		grp.runs[2].value = carry_n;
		grp.runs[2].count = spld_pkg::CNT_OUT_W'(1);
		grp.runs[2].done  = (b3 >= cap);

		grp.runs[3].value = 8'h00;
		grp.runs[3].count = spld_pkg::cnt_out(cap - b3);
		grp.runs[3].done  = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			left_q    <= '0;
			carry_q   <= '0;
			pos_q     <= '0;
			started_q <= 1'b0;
		end else if (adv) begin
			if (itm_last_s1) begin
				phase_q   <= PH_HDR;
				left_q    <= '0;
				carry_q   <= '0;
				pos_q     <= '0;
				started_q <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				left_q    <= left_n;
				carry_q   <= carry_n;
				pos_q     <= b2;
				started_q <= 1'b1;
			end
		end
	end

	a_lit_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LIT |-> left_q != 8'd0)
		else $error("literal phase with no bytes left");

	a_idle_line_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> phase_q == PH_HDR)
		else $error("line not started but parser mid-run");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && itm_last_s1 |=> !started_q && pos_q == '0)
		else $error("final code beat did not close the line");

endmodule

FILE: src/spld_drain.sv
// Result register holding one beat's run group; hands out one run per cycle while run_stall is low.
// Depends on spld_pkg; loaded by spld_core.
module spld_drain (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            grp_load,
	input  spld_pkg::grp_t                  grp,
	output logic                            grp_ready,
	output logic                            run_valid,
	input  logic                            run_stall,
	output logic [7:0]                      out_byte,
	output logic [spld_pkg::CNT_OUT_W-1:0]  repeat_count,
	output logic                            last_of_item,
	output logic                            line_done
);

	logic [spld_pkg::NRUN-1:0] mask_q;
	spld_pkg::run_t [spld_pkg::NRUN-1:0] runs_q;

	logic [1:0]                sel;
	logic                      found;
	logic [spld_pkg::NRUN-1:0] rest;
	logic                      take;

	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int i = 0; i < spld_pkg::NRUN; i++) begin
			if (mask_q[i] && !found) begin
				sel   = 2'(i);
				found = 1'b1;
			end
		end
		rest = mask_q & ~(spld_pkg::NRUN'(1) << sel);
	end

	assign run_valid    = |mask_q;
	assign take         = run_valid && !run_stall;
	assign grp_ready    = !run_valid || (take && rest == '0);
	assign out_byte     = runs_q[sel].value;
	assign repeat_count = runs_q[sel].count;
	assign line_done    = runs_q[sel].done;
	assign last_of_item = (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (grp_load) begin
			mask_q <= grp.mask;
		end else if (take) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			runs_q <= grp.runs;
		end
	end

	a_done_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && line_done |-> last_of_item)
		else $error("run after the one that filled the line");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> repeat_count != '0)
		else $error("empty run presented");

endmodule

FILE: src/shifted_packbits_line_decoder.sv
// Run-length coded raster line decoder with bit shift: top level.
// Instantiates spld_cfg, spld_core and spld_drain; uses spld_pkg.
// Takes one coded byte per beat and returns runs (byte value plus repeat count) of the
// decoded line, shifted right by bit_offset, led by bit_offset/8 zero bytes and padded to
// line_bits. A coded byte is registered, decoded combinationally into up to four runs, and
// the run group waits in a result register that hands out one run per cycle while
// run_stall is low; the input register lets the next beat enter while a run waits. The
// result register lies between the input register and the run outputs. Registers are
// written via APB at 0x0 (bit_offset) and 0x4 (line_bits); the user is to write them
// between lines, which the block itself does not enforce.
module shifted_packbits_line_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spld_pkg::ADDR_W-1:0]     paddr,
	input  logic [spld_pkg::DATA_W-1:0]     pwdata,
	output logic [spld_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            code_valid,
	output logic                            code_stall,
	input  logic [7:0]                      code_byte,
	input  logic                            end_of_code,
	output logic                            run_valid,
	input  logic                            run_stall,
	output logic [7:0]                      out_byte,
	output logic [spld_pkg::CNT_OUT_W-1:0]  repeat_count,
	output logic                            last_of_item,
	output logic                            line_done
);

	spld_pkg::cfg_t cfg;
	spld_pkg::grp_t grp;
	logic           grp_ready;
	logic           grp_load;

	spld_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spld_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_valid  (code_valid),
		.code_stall  (code_stall),
		.code_byte   (code_byte),
		.end_of_code (end_of_code),
		.cfg         (cfg),
		.grp_ready   (grp_ready),
		.grp_load    (grp_load),
		.grp         (grp)
	);

	spld_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_load     (grp_load),
		.grp          (grp),
		.grp_ready    (grp_ready),
		.run_valid    (run_valid),
		.run_stall    (run_stall),
		.out_byte     (out_byte),
		.repeat_count (repeat_count),
		.last_of_item (last_of_item),
		.line_done    (line_done)
	);

endmodule

FILE: tb/sv/shifted_packbits_line_decoder_test.sv
// Self-checking testbench for shifted_packbits_line_decoder: directed table, then random lines.
// Depends on spld_pkg and the decoder RTL only; expects every run beat (typed or predicted) and checks it in order.
module shifted_packbits_line_decoder_test;

	localparam int RANDOM_ITEMS = 460;
	localparam int SETTLE       = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;

	localparam logic [spld_pkg::ADDR_W-1:0] ADDR_OFFSET = {spld_pkg::REG_OFFSET, 2'b00};
	localparam logic [spld_pkg::ADDR_W-1:0] ADDR_LINE   = {spld_pkg::REG_LINE, 2'b00};

	typedef enum logic [1:0] {AT_HEADER, IN_LITERAL, IN_REPEAT} parse_t;
	typedef enum logic [1:0] {ROW_CODE, ROW_OFS, ROW_LEN} row_kind_t;

	typedef struct packed {
		logic [7:0]                     value;
		logic [spld_pkg::CNT_OUT_W-1:0] cnt;
		logic                           last;
		logic                           done;
	} line_run_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [15:0]       data;
		logic              eoc;
		logic signed [2:0] nexp;
		line_run_t         r0;
		line_run_t         r1;
	} dir_row_t;

	localparam logic signed [2:0] PREDICT = -3'sd1;
	localparam line_run_t NO_RUN = '0;
	localparam int N_DIR = 37;

	// nexp >= 0: the runs are typed in here; PREDICT: the decoder below supplies them
	dir_row_t dir_rows [N_DIR] = '{
		'{ROW_CODE, 16'h00, 1'b0, 3'sd0, NO_RUN, NO_RUN},	// empty line, nothing out
		'{ROW_CODE, 16'hFF, 1'b1, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_LEN,  16'd64, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h00, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'hA5, 1'b0, 3'sd1, '{8'hA5, 12'd1, 1'b1, 1'b0}, NO_RUN},
		'{ROW_CODE, 16'hFF, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h3C, 1'b0, 3'sd2, '{8'h3C, 12'd1, 1'b0, 1'b0},
			'{8'h3C, 12'd1, 1'b1, 1'b0}},
		'{ROW_CODE, 16'h80, 1'b0, 3'sd0, NO_RUN, NO_RUN},	// 129 repeats, clipped
		'{ROW_CODE, 16'h11, 1'b0, 3'sd2, '{8'h11, 12'd1, 1'b0, 1'b0},
			'{8'h11, 12'd4, 1'b1, 1'b1}},
		'{ROW_CODE, 16'h00, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h77, 1'b1, 3'sd0, NO_RUN, NO_RUN},	// line already full
		'{ROW_OFS,  16'h3FFF, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_LEN,  16'h7FFF, 1'b0, 3'sd0, NO_RUN, NO_RUN},	// clamps to max length
		'{ROW_CODE, 16'h00, 1'b0, 3'sd1, '{8'h00, 12'd2047, 1'b1, 1'b0}, NO_RUN},
		'{ROW_CODE, 16'hFF, 1'b1, PREDICT, NO_RUN, NO_RUN},
		'{ROW_OFS,  16'd3, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_LEN,  16'd100, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h00, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'hF0, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'hFD, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'hAA, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h02, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h55, 1'b1, PREDICT, NO_RUN, NO_RUN},	// ends inside literal
		'{ROW_OFS,  16'd200, 1'b0, 3'sd0, NO_RUN, NO_RUN},	// offset past line end
		'{ROW_LEN,  16'd40, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h00, 1'b0, 3'sd1, '{8'h00, 12'd5, 1'b1, 1'b1}, NO_RUN},
		'{ROW_CODE, 16'h99, 1'b1, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_OFS,  16'd4, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_LEN,  16'd48, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h00, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h81, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_OFS,  16'd13, 1'b0, 3'sd0, NO_RUN, NO_RUN},	// mid-line offset change
		'{ROW_CODE, 16'hFE, 1'b0, PREDICT, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h42, 1'b1, PREDICT, NO_RUN, NO_RUN},	// ends inside repeat
		'{ROW_OFS,  16'd0, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_LEN,  16'd8, 1'b0, 3'sd0, NO_RUN, NO_RUN},
		'{ROW_CODE, 16'h05, 1'b1, 3'sd1, '{8'h00, 12'd1, 1'b1, 1'b1}, NO_RUN}	// ends on header
	};

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [spld_pkg::ADDR_W-1:0]    paddr;
	logic [spld_pkg::DATA_W-1:0]    pwdata;
	logic [spld_pkg::DATA_W-1:0]    prdata;
	logic                           pready;
	logic                           code_valid;
	logic                           code_stall;
	logic [7:0]                     code_byte;
	logic                           end_of_code;
	logic                           run_valid;
	logic                           run_stall;
	logic [7:0]                     out_byte;
	logic [spld_pkg::CNT_OUT_W-1:0] repeat_count;
	logic                           last_of_item;
	logic                           line_done;

	shifted_packbits_line_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.code_valid(code_valid), .code_stall(code_stall),
		.code_byte(code_byte), .end_of_code(end_of_code),
		.run_valid(run_valid), .run_stall(run_stall),
		.out_byte(out_byte), .repeat_count(repeat_count),
		.last_of_item(last_of_item), .line_done(line_done)
	);

	// decoder state mirrored here
	logic [spld_pkg::OFS_W-1:0] ofs_reg = '0;
	logic [spld_pkg::LEN_W-1:0] len_reg = '0;
	parse_t           phase = AT_HEADER;
	int unsigned      left = 0;
	int unsigned      carry = 0;
	int unsigned      pos = 0;
	bit               started = 0;

	line_run_t item_runs[$];
	line_run_t runs_due[$];

	// typed expectation of the beat on the code port
	logic signed [2:0] cur_nexp = PREDICT;
	line_run_t         cur_r0 = NO_RUN;
	line_run_t         cur_r1 = NO_RUN;

	int  fails = 0;
	int  cycles = 0;
	int  runs_seen = 0;
	int  items_sent = 0;
	bit  no_idle = 0;
	bit  took_run = 0;
	bit  held_once = 0;
	int  stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_bits();
		return (int'(len_reg) > spld_pkg::MAX_LINE_BITS) ? spld_pkg::MAX_LINE_BITS :
			int'(len_reg);
	endfunction

	function automatic int unsigned room_left();
		int unsigned lb;
		lb = eff_bits();
		return (pos < lb) ? (lb - pos) / 8 : 0;
	endfunction

	function automatic void emit_run(int unsigned value, int unsigned count);
		int unsigned lb;
		bit          short_before;
		line_run_t   r;
		lb = eff_bits();
		short_before = pos < lb;
		pos += 8 * count;
		r.value = value[7:0];
		r.cnt = count[spld_pkg::CNT_OUT_W-1:0];
		r.last = 1'b0;
		r.done = short_before && pos >= lb;
		item_runs.push_back(r);
	endfunction

	function automatic void decode_byte(logic [7:0] d, logic eoc);
		int unsigned sh, lb, lead, cap, cnt, lo, dv;
		sh = int'(ofs_reg) % 8;
		lb = eff_bits();
		dv = d;
		item_runs.delete();
		if (!started) begin
			lead = int'(ofs_reg) / 8;
			cap = (lb + 7) / 8;
			if (lead > cap)
				lead = cap;
			started = 1;
			carry = 0;
			pos = 0;
			if (lead > 0)
				emit_run(0, lead);
		end
		case (phase)
			AT_HEADER: begin
				if (dv < 128) begin
					left = dv + 1;
					phase = IN_LITERAL;
				end else begin
					left = 257 - dv;
					phase = IN_REPEAT;
				end
			end
			IN_LITERAL: begin
				if (room_left() > 0) begin
					emit_run(carry | (dv >> sh), 1);
					carry = (dv << (8 - sh)) & 8'hff;
				end
				left = (left - 1) & 8'hff;
				if (left == 0)
					phase = AT_HEADER;
			end
			default: begin
				cnt = left;
				if (cnt > room_left())
					cnt = room_left();
				if (cnt > 0) begin
					lo = (dv << (8 - sh)) & 8'hff;
					emit_run(carry | (dv >> sh), 1);
					if (cnt > 1)
						emit_run(lo | (dv >> sh), cnt - 1);
					carry = lo;
				end
				left = 0;
				phase = AT_HEADER;
			end
		endcase
		if (eoc) begin
			if (pos < lb)
				emit_run(carry, 1);
			if (pos < lb)
				emit_run(0, (lb - pos + 7) / 8);
			phase = AT_HEADER;
			left = 0;
			carry = 0;
			pos = 0;
			started = 0;
		end
		if (item_runs.size() > 0)
			item_runs[item_runs.size() - 1].last = 1'b1;
	endfunction

	// prediction and checking, all at the rising edge
	always @(posedge clk) begin
		line_run_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_OFFSET: ofs_reg = pwdata[spld_pkg::OFS_W-1:0];
					ADDR_LINE:   len_reg = pwdata[spld_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			if (code_valid && !code_stall) begin
				decode_byte(code_byte, end_of_code);
				if (cur_nexp == PREDICT) begin
					foreach (item_runs[i])
						runs_due.push_back(item_runs[i]);
				end else begin
					if (cur_nexp > 0)
						runs_due.push_back(cur_r0);
					if (cur_nexp > 1)
						runs_due.push_back(cur_r1);
				end
			end
			if (run_valid && !run_stall) begin
				took_run = 1;
				runs_seen++;
				if (runs_due.size() == 0) begin
					$error("unexpected run beat: out_byte %0h repeat_count %0d",
						out_byte, repeat_count);
					fails++;
				end else begin
					want = runs_due.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %0h, got %0h", want.value, out_byte);
						fails++;
					end
					if (repeat_count !== want.cnt) begin
						$error("repeat_count: expected %0d, got %0d", want.cnt, repeat_count);
						fails++;
					end
					if (last_of_item !== want.last) begin
						$error("last_of_item: expected %0b, got %0b", want.last, last_of_item);
						fails++;
					end
					if (line_done !== want.done) begin
						$error("line_done: expected %0b, got %0b", want.done, line_done);
						fails++;
					end
				end
			end
		end
	end

	// result side: random stall per beat, one long hold to back up the block
	always @(negedge clk) begin
		if (took_run) begin
			took_run = 0;
			if (!held_once && runs_seen >= HOLD_AFTER) begin
				held_once = 1;
				stall_left = HOLD_CYCLES;
			end else begin
				stall_left = no_idle ? 0 : $urandom_range(0, 4);
			end
		end
		if (stall_left > 0) begin
			run_stall <= 1'b1;
			stall_left--;
		end else begin
			run_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// called and returns at a falling edge
	task automatic send_code(input logic [7:0] b, input logic eoc,
		input logic signed [2:0] nexp, input line_run_t r0, input line_run_t r1);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			code_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_nexp = nexp;
		cur_r0 = r0;
		cur_r1 = r1;
		code_byte <= b;
		end_of_code <= eoc;
		code_valid <= 1'b1;
		do
			@(posedge clk);
		while (code_stall);
		@(negedge clk);
	endtask

	// waits for the block to drain, writes a register and reads it back
	task automatic cfg_write(input logic [spld_pkg::ADDR_W-1:0] addr,
		input logic [spld_pkg::DATA_W-1:0] value);
		logic [spld_pkg::DATA_W-1:0] want;
		want = (addr == ADDR_OFFSET) ? (value & ((1 << spld_pkg::OFS_W) - 1)) :
			(value & ((1 << spld_pkg::LEN_W) - 1));
		code_valid <= 1'b0;
		while (runs_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata: expected %0h, got %0h", want, prdata);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_line();
		logic [7:0] bytes_q[$];
		int kind, n, cut, r;
		no_idle = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1)) begin
			r = $urandom_range(0, 9);
			cfg_write(ADDR_OFFSET, (r == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 24));
		end
		if ($urandom_range(0, 1)) begin
			r = $urandom_range(0, 9);
			cfg_write(ADDR_LINE, (r == 0) ? $urandom_range(0, 32767) :
				(r == 1) ? 0 : $urandom_range(1, 320));
		end
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			// noise
			n = $urandom_range(1, 10);
			repeat (n) bytes_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 1)) begin
					n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) :
						$urandom_range(1, 8);
					bytes_q.push_back(8'(n - 1));
					repeat (n) bytes_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					n = $urandom_range(2, 129);
					bytes_q.push_back(8'(257 - n));
					bytes_q.push_back(8'($urandom_range(0, 255)));
				end
			end
			// broken line: end of code lands early
			if (kind <= 3) begin
				cut = $urandom_range(1, bytes_q.size());
				while (bytes_q.size() > cut)
					void'(bytes_q.pop_back());
			end
		end
		foreach (bytes_q[i])
			send_code(bytes_q[i], i == bytes_q.size() - 1, PREDICT, NO_RUN, NO_RUN);
		items_sent += bytes_q.size();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		code_valid = 1'b0;
		code_byte = '0;
		end_of_code = 1'b0;
		run_stall = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_OFS: cfg_write(ADDR_OFFSET, spld_pkg::DATA_W'(dir_rows[i].data));
				ROW_LEN: cfg_write(ADDR_LINE, spld_pkg::DATA_W'(dir_rows[i].data));
				default: send_code(dir_rows[i].data[7:0], dir_rows[i].eoc,
					dir_rows[i].nexp, dir_rows[i].r0, dir_rows[i].r1);
			endcase
		end
		while (items_sent < RANDOM_ITEMS)
			random_line();
		code_valid <= 1'b0;
		while (runs_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: shifted_packbits_line_decoder.f
src/spld_pkg.sv
src/spld_cfg.sv
src/spld_core.sv
src/spld_drain.sv
src/shifted_packbits_line_decoder.sv
tb/sv/shifted_packbits_line_decoder_test.sv
